### rtl/mss_pkg.sv
// Shared types, codes and widths for the motion system mode supervisor.
`default_nettype none

package mss_pkg;

   localparam int MAX_AXES   = 8;
   localparam int AXIS_W     = 8;
   localparam int AXIS_IDX_W = 3;
   localparam int CMD_W      = 4;
   localparam int CNT_W      = 4;
   localparam int TICK_W     = 16;
   localparam int SYNC_W     = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CNT_W-1:0]  AXES_RESET    = CNT_W'(8);
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(100);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AXES = 1'b0,
      CSR_RECOVER_TIMEOUT = 1'b1
   } csr_index_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET_CONFIGURED = 4'd0,
      CMD_INIT           = 4'd1,
      CMD_ENABLE         = 4'd2,
      CMD_DISABLE        = 4'd3,
      CMD_RELEASE        = 4'd4,
      CMD_HALT           = 4'd5,
      CMD_RECOVER        = 4'd6,
      CMD_SHUTDOWN       = 4'd7,
      CMD_TICK           = 4'd8
   } cmd_type;

   typedef enum logic [2:0] {
      MODE_INACTIVE      = 3'd0,
      MODE_CONFIGURED    = 3'd1,
      MODE_STANDBY       = 3'd2,
      MODE_ARMED         = 3'd3,
      MODE_RUNNING       = 3'd4,
      MODE_FAULTED       = 3'd5,
      MODE_RECOVERING    = 3'd6,
      MODE_SHUTTING_DOWN = 3'd7
   } mode_type;

   typedef enum logic [3:0] {
      ST_MOVED           = 4'd0,
      ST_ALREADY         = 4'd1,
      ST_ILLEGAL         = 4'd2,
      ST_START_FAIL      = 4'd3,
      ST_NOT_RUNNING     = 4'd4,
      ST_FAULT_LATCHED   = 4'd5,
      ST_AXIS_FAULT      = 4'd6,
      ST_HEARTBEAT       = 4'd7,
      ST_RESET_FAIL      = 4'd8,
      ST_RECOVER_PENDING = 4'd9,
      ST_RECOVER_TIMEOUT = 4'd10,
      ST_GRACEFUL_FAIL   = 4'd11,
      ST_AUTO_FAULTED    = 4'd12,
      ST_NO_CHANGE       = 4'd13
   } status_type;

   typedef enum logic [1:0] {
      INTENT_DISABLE = 2'd0,
      INTENT_HALT    = 2'd1,
      INTENT_RUN     = 2'd2
   } intent_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [AXIS_W-1:0] fault_bits;
      logic [AXIS_W-1:0] hb_lost_bits;
      logic              start_ok;
      logic              running;
      logic              reset_ok;
      logic              stop_ok;
   } req_type;

   typedef struct packed {
      mode_type          mode;
      logic              fault_latch;
      logic              halted;
      logic [TICK_W-1:0] elapsed;
      logic [SYNC_W-1:0] sync;
   } state_type;

   typedef struct packed {
      logic                  success;
      status_type            status;
      mode_type              mode_now;
      intent_type            intent;
      logic                  fault_latched;
      logic                  halted_by_fault;
      logic [AXIS_IDX_W-1:0] bad_axis;
      logic [SYNC_W-1:0]     sync_sequence;
   } rsp_type;

   typedef struct packed {
      logic                  found;
      logic [AXIS_IDX_W-1:0] index;
   } lowest_type;

   function automatic lowest_type lowest_bit(input logic [AXIS_W-1:0] bits);
      lowest_type r;
      r.found = 1'b0;
      r.index = '0;
      for (int i = AXIS_W - 1; i >= 0; i--) begin
         if (bits[i]) begin
            r.found = 1'b1;
            r.index = AXIS_IDX_W'(i);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/mss_req_stage.sv
// Input register stage holding one accepted request transaction.
`default_nettype none

module mss_req_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire logic             drain,
   input  wire mss_pkg::req_type req_in,
   output logic                  valid_out,
   output mss_pkg::req_type      req_out
);

   logic             valid_ff;
   logic             valid_in;
   mss_pkg::req_type req_ff;

   always_comb begin
      valid_in = valid_ff;
      if (drain) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         req_ff <= req_in;
      end
   end

   assign valid_out = valid_ff;
   assign req_out   = req_ff;

endmodule

`default_nettype wire

### rtl/mss_step.sv
// Mode transition logic: one request against the current supervisor state.
`default_nettype none

module mss_step (
   input  wire mss_pkg::req_type             req,
   input  wire mss_pkg::state_type           state_cur,
   input  wire logic [mss_pkg::CNT_W-1:0]    axes,
   input  wire logic [mss_pkg::TICK_W-1:0]   recover_timeout,
   output mss_pkg::state_type                state_next,
   output mss_pkg::rsp_type                  rsp
);

   logic [mss_pkg::AXIS_W-1:0] mask;
   logic [mss_pkg::AXIS_W-1:0] flt;
   logic [mss_pkg::AXIS_W-1:0] hb;
   logic [mss_pkg::AXIS_W-1:0] sick;
   mss_pkg::lowest_type        lb_sick;
   mss_pkg::lowest_type        lb_flt;
   mss_pkg::lowest_type        lb_hb;
   logic [mss_pkg::TICK_W-1:0] limit;
   logic [mss_pkg::TICK_W-1:0] elapsed_inc;
   logic [mss_pkg::SYNC_W-1:0] sync_inc;

   always_comb begin
      for (int i = 0; i < mss_pkg::AXIS_W; i++) begin
         mask[i] = (i < mss_pkg::MAX_AXES) && (axes > mss_pkg::CNT_W'(i));
      end
      flt         = req.fault_bits & mask;
      hb          = req.hb_lost_bits & mask;
      sick        = flt | hb;
      lb_sick     = mss_pkg::lowest_bit(sick);
      lb_flt      = mss_pkg::lowest_bit(flt);
      lb_hb       = mss_pkg::lowest_bit(hb);
      limit       = (recover_timeout == '0) ? mss_pkg::TICK_W'(1) : recover_timeout;
      elapsed_inc = state_cur.elapsed + mss_pkg::TICK_W'(1);
      sync_inc    = state_cur.sync + mss_pkg::SYNC_W'(1);
   end

   mss_pkg::status_type           st;
   logic                          ok;
   logic [mss_pkg::AXIS_IDX_W-1:0] bad;
   mss_pkg::state_type            nx;

   always_comb begin
      nx  = state_cur;
      st  = mss_pkg::ST_MOVED;
      ok  = 1'b1;
      bad = lb_sick.index;
      unique case (req.cmd)
         mss_pkg::CMD_SET_CONFIGURED: begin
            st = (state_cur.mode == mss_pkg::MODE_CONFIGURED) ?
                 mss_pkg::ST_ALREADY : mss_pkg::ST_MOVED;
            nx.mode = mss_pkg::MODE_CONFIGURED;
         end
         mss_pkg::CMD_INIT: begin
            if (state_cur.mode != mss_pkg::MODE_CONFIGURED) begin
               ok = (state_cur.mode == mss_pkg::MODE_ARMED);
               st = ok ? mss_pkg::ST_ALREADY : mss_pkg::ST_ILLEGAL;
            end else begin
               ok = 1'b0;
               if (!req.start_ok) begin
                  st = mss_pkg::ST_START_FAIL;
               end else if (!req.running) begin
                  nx.mode = mss_pkg::MODE_STANDBY;
                  st      = mss_pkg::ST_NOT_RUNNING;
               end else if (lb_flt.found || state_cur.fault_latch) begin
                  nx.fault_latch = 1'b1;
                  nx.halted      = 1'b1;
                  nx.mode        = mss_pkg::MODE_FAULTED;
                  if (lb_flt.found) begin
                     st  = mss_pkg::ST_AXIS_FAULT;
                     bad = lb_flt.index;
                  end else begin
                     st = mss_pkg::ST_FAULT_LATCHED;
                  end
               end else if (lb_hb.found) begin
                  nx.fault_latch = 1'b0;
                  nx.halted      = 1'b0;
                  nx.mode        = mss_pkg::MODE_STANDBY;
                  st             = mss_pkg::ST_HEARTBEAT;
                  bad            = lb_hb.index;
               end else begin
                  nx.fault_latch = 1'b0;
                  nx.halted      = 1'b0;
                  nx.sync        = sync_inc;
                  nx.mode        = mss_pkg::MODE_ARMED;
                  ok             = 1'b1;
               end
            end
         end
         mss_pkg::CMD_ENABLE, mss_pkg::CMD_RELEASE: begin
            if ((req.cmd == mss_pkg::CMD_ENABLE &&
                 state_cur.mode != mss_pkg::MODE_STANDBY) ||
                (req.cmd == mss_pkg::CMD_RELEASE &&
                 state_cur.mode != mss_pkg::MODE_ARMED)) begin
               ok = (req.cmd == mss_pkg::CMD_ENABLE) ?
                    (state_cur.mode == mss_pkg::MODE_ARMED) :
                    (state_cur.mode == mss_pkg::MODE_RUNNING);
               st = ok ? mss_pkg::ST_ALREADY : mss_pkg::ST_ILLEGAL;
            end else begin
               ok = 1'b0;
               if (!req.running) begin
                  st = mss_pkg::ST_NOT_RUNNING;
               end else if (state_cur.fault_latch) begin
                  st = mss_pkg::ST_FAULT_LATCHED;
               end else if (lb_sick.found) begin
                  st = flt[lb_sick.index] ? mss_pkg::ST_AXIS_FAULT : mss_pkg::ST_HEARTBEAT;
               end else begin
                  nx.mode = (req.cmd == mss_pkg::CMD_ENABLE) ?
                            mss_pkg::MODE_ARMED : mss_pkg::MODE_RUNNING;
                  ok      = 1'b1;
               end
            end
         end
         mss_pkg::CMD_DISABLE: begin
            if (state_cur.mode != mss_pkg::MODE_STANDBY &&
                state_cur.mode != mss_pkg::MODE_ARMED &&
                state_cur.mode != mss_pkg::MODE_RUNNING) begin
               ok = 1'b0;
               st = mss_pkg::ST_ILLEGAL;
            end else if (!req.running) begin
               ok = 1'b0;
               st = mss_pkg::ST_NOT_RUNNING;
            end else begin
               nx.mode = mss_pkg::MODE_STANDBY;
            end
         end
         mss_pkg::CMD_HALT: begin
            if (state_cur.mode != mss_pkg::MODE_RUNNING) begin
               ok = (state_cur.mode == mss_pkg::MODE_ARMED);
               st = ok ? mss_pkg::ST_ALREADY : mss_pkg::ST_ILLEGAL;
            end else begin
               nx.mode = mss_pkg::MODE_ARMED;
            end
         end
         mss_pkg::CMD_RECOVER: begin
            if (state_cur.mode != mss_pkg::MODE_FAULTED) begin
               ok = (state_cur.mode == mss_pkg::MODE_STANDBY);
               st = ok ? mss_pkg::ST_ALREADY : mss_pkg::ST_ILLEGAL;
            end else begin
               ok = 1'b0;
               if (!req.running) begin
                  st = mss_pkg::ST_NOT_RUNNING;
               end else if (!req.reset_ok) begin
                  st = mss_pkg::ST_RESET_FAIL;
               end else if (!lb_sick.found) begin
                  nx.fault_latch = 1'b0;
                  nx.halted      = 1'b0;
                  nx.sync        = sync_inc;
                  nx.mode        = mss_pkg::MODE_STANDBY;
                  ok             = 1'b1;
               end else begin
                  nx.elapsed = '0;
                  nx.mode    = mss_pkg::MODE_RECOVERING;
                  st         = mss_pkg::ST_RECOVER_PENDING;
               end
            end
         end
         mss_pkg::CMD_SHUTDOWN: begin
            nx.elapsed = '0;
            nx.mode    = mss_pkg::MODE_CONFIGURED;
            if (req.running && !req.stop_ok) begin
               st = mss_pkg::ST_GRACEFUL_FAIL;
               ok = 1'b0;
            end else begin
               nx.fault_latch = 1'b0;
               nx.halted      = 1'b0;
               nx.sync        = sync_inc;
            end
         end
         mss_pkg::CMD_TICK: begin
            if (state_cur.mode == mss_pkg::MODE_RECOVERING) begin
               if (!lb_sick.found) begin
                  nx.fault_latch = 1'b0;
                  nx.halted      = 1'b0;
                  nx.sync        = sync_inc;
                  nx.mode        = mss_pkg::MODE_STANDBY;
               end else begin
                  nx.elapsed = elapsed_inc;
                  ok         = 1'b0;
                  if (elapsed_inc >= limit) begin
                     nx.mode = mss_pkg::MODE_FAULTED;
                     st      = mss_pkg::ST_RECOVER_TIMEOUT;
                  end else begin
                     st = mss_pkg::ST_RECOVER_PENDING;
                  end
               end
            end else if ((state_cur.mode == mss_pkg::MODE_ARMED ||
                          state_cur.mode == mss_pkg::MODE_RUNNING) && lb_sick.found) begin
               nx.mode        = mss_pkg::MODE_FAULTED;
               nx.fault_latch = 1'b1;
               nx.halted      = 1'b1;
               st             = mss_pkg::ST_AUTO_FAULTED;
               ok             = 1'b0;
            end else begin
               st = mss_pkg::ST_NO_CHANGE;
            end
         end
         default: begin
            st = mss_pkg::ST_ILLEGAL;
            ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_next          = nx;
      rsp.success         = ok;
      rsp.status          = st;
      rsp.mode_now        = nx.mode;
      rsp.fault_latched   = nx.fault_latch;
      rsp.halted_by_fault = nx.halted;
      rsp.bad_axis        = bad;
      rsp.sync_sequence   = nx.sync;
      unique case (nx.mode)
         mss_pkg::MODE_RUNNING: rsp.intent = mss_pkg::INTENT_RUN;
         mss_pkg::MODE_ARMED,
         mss_pkg::MODE_FAULTED,
         mss_pkg::MODE_RECOVERING: rsp.intent = mss_pkg::INTENT_HALT;
         default: rsp.intent = mss_pkg::INTENT_DISABLE;
      endcase
   end

endmodule

`default_nettype wire

### rtl/motion_system_mode_supervisor_top.sv
// Top level of the motion system mode supervisor: handshakes, state and result register.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | cmd, axis flags, master status bits
//   rsp     | out       | rsp_valid/rsp_ready | success, status, mode, intent, flags, axis, sync
//   csr     | in        | csr_we              | csr_index, csr_data (no read-back)
//
// One transaction per cycle while rsp_ready is high; rsp_valid rises as a result loads.
// The mode update is one pass of combinational logic between the request register and
// the result register, committed to the state when the result is loaded.
// Reset is synchronous, active high; it clears the mode, latches and counters and
// restores the registers to axis count 8 and recover timeout 100 ticks.
// A stalled rsp holds the result register; req_ready drops only when both stages are full.
`default_nettype none

module motion_system_mode_supervisor_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [mss_pkg::CMD_W-1:0]         req_cmd,
   input  wire logic [mss_pkg::AXIS_W-1:0]        req_axis_fault_bits,
   input  wire logic [mss_pkg::AXIS_W-1:0]        req_axis_heartbeat_lost_bits,
   input  wire logic                              req_master_start_ok,
   input  wire logic                              req_master_running,
   input  wire logic                              req_fault_reset_ok,
   input  wire logic                              req_graceful_stop_ok,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_success,
   output logic [3:0]                             rsp_status,
   output logic [2:0]                             rsp_mode_now,
   output logic [1:0]                             rsp_axis_intent,
   output logic                                   rsp_global_fault_out,
   output logic                                   rsp_halted_by_fault_out,
   output logic [mss_pkg::AXIS_IDX_W-1:0]         rsp_bad_axis,
   output logic [mss_pkg::SYNC_W-1:0]             rsp_sync_sequence,
   input  wire logic                              csr_we,
   input  wire logic [mss_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mss_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic [mss_pkg::CNT_W-1:0]  axes_ff;
   logic [mss_pkg::TICK_W-1:0] timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         axes_ff    <= mss_pkg::AXES_RESET;
         timeout_ff <= mss_pkg::TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (mss_pkg::csr_index_type'(csr_index))
            mss_pkg::CSR_AXES:            axes_ff    <= csr_data[mss_pkg::CNT_W-1:0];
            mss_pkg::CSR_RECOVER_TIMEOUT: timeout_ff <= csr_data[mss_pkg::TICK_W-1:0];
            default: ;
         endcase
      end
   end

   mss_pkg::req_type   req_in;
   mss_pkg::req_type   stage_req;
   logic               stage_valid;
   logic               advance;
   logic               req_accept;
   logic               out_valid_ff;
   logic               out_valid_in;
   mss_pkg::rsp_type   out_ff;
   mss_pkg::rsp_type   step_rsp;
   mss_pkg::state_type state_ff;
   mss_pkg::state_type state_in;

   assign req_in.cmd          = req_cmd;
   assign req_in.fault_bits   = req_axis_fault_bits;
   assign req_in.hb_lost_bits = req_axis_heartbeat_lost_bits;
   assign req_in.start_ok     = req_master_start_ok;
   assign req_in.running      = req_master_running;
   assign req_in.reset_ok     = req_fault_reset_ok;
   assign req_in.stop_ok      = req_graceful_stop_ok;

   assign advance    = stage_valid && (!out_valid_ff || rsp_ready);
   assign req_ready  = !stage_valid || advance;
   assign req_accept = req_valid && req_ready;

   mss_req_stage u_req_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .drain     (advance),
      .req_in    (req_in),
      .valid_out (stage_valid),
      .req_out   (stage_req)
   );

   mss_step u_step (
      .req             (stage_req),
      .state_cur       (state_ff),
      .axes            (axes_ff),
      .recover_timeout (timeout_ff),
      .state_next      (state_in),
      .rsp             (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode        <= mss_pkg::MODE_INACTIVE;
         state_ff.fault_latch <= 1'b0;
         state_ff.halted      <= 1'b0;
         state_ff.elapsed     <= '0;
         state_ff.sync        <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_rsp;
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_success             = out_ff.success;
   assign rsp_status              = out_ff.status;
   assign rsp_mode_now            = out_ff.mode_now;
   assign rsp_axis_intent         = out_ff.intent;
   assign rsp_global_fault_out    = out_ff.fault_latched;
   assign rsp_halted_by_fault_out = out_ff.halted_by_fault;
   assign rsp_bad_axis            = out_ff.bad_axis;
   assign rsp_sync_sequence       = out_ff.sync_sequence;

   a_latch_tracks_halt: assert property (@(posedge clock) disable iff (reset)
      state_ff.halted == state_ff.fault_latch)
      else $error("halted flag and fault latch diverged");

   a_sync_steps_by_one: assert property (@(posedge clock) disable iff (reset)
      advance |=> (state_ff.sync == $past(state_ff.sync)) ||
                  (state_ff.sync == $past(state_ff.sync) + mss_pkg::SYNC_W'(1)))
      else $error("sync counter moved by more than one");

   a_pending_in_recovery: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == mss_pkg::ST_RECOVER_PENDING) |->
      (rsp_mode_now == mss_pkg::MODE_RECOVERING && !rsp_success))
      else $error("recover pending outside recovering mode");

   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_mode_now == state_ff.mode && rsp_sync_sequence == state_ff.sync))
      else $error("result register and mode state disagree");

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the motion system mode supervisor: predicted results vs. DUT.
`timescale 1ns / 1ps

class supervisor_scoreboard;
   mss_pkg::mode_type          mode;
   logic                       latch;
   logic                       halted;
   logic [mss_pkg::TICK_W-1:0] elapsed;
   logic [mss_pkg::SYNC_W-1:0] sync;
   logic [mss_pkg::CNT_W-1:0]  axes;
   logic [mss_pkg::TICK_W-1:0] recover_ticks;
   mss_pkg::rsp_type           outcomes_due[$];
   int                         failures;
   int                         requests;
   int                         responses;
   int                         status_seen[16];

   function new();
      mode = mss_pkg::MODE_INACTIVE;
      latch = 1'b0;
      halted = 1'b0;
      elapsed = '0;
      sync = '0;
      axes = mss_pkg::AXES_RESET;
      recover_ticks = mss_pkg::TIMEOUT_RESET;
      failures = 0;
      requests = 0;
      responses = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
   endfunction

   function void set_registers(logic [mss_pkg::CSR_DATA_W-1:0] count_word,
                               logic [mss_pkg::TICK_W-1:0] ticks);
      axes = count_word[mss_pkg::CNT_W-1:0];
      recover_ticks = ticks;
   endfunction

   function int pending();
      return outcomes_due.size();
   endfunction

   function int first_set(logic [mss_pkg::AXIS_W-1:0] bits);
      for (int i = 0; i < mss_pkg::AXIS_W; i++)
         if (bits[i]) return i;
      return -1;
   endfunction

   function logic [7:0] mode_bit(mss_pkg::mode_type m);
      return 8'(1) << m;
   endfunction

   function bit admitted(logic [7:0] from_modes, mss_pkg::mode_type target,
                         output mss_pkg::status_type st, output logic ok);
      st = mss_pkg::ST_MOVED;
      ok = 1'b1;
      if (from_modes[mode]) return 1'b1;
      if (mode == target) st = mss_pkg::ST_ALREADY;
      else begin
         st = mss_pkg::ST_ILLEGAL;
         ok = 1'b0;
      end
      return 1'b0;
   endfunction

   function void clear_faults_and_sync();
      latch = 1'b0;
      halted = 1'b0;
      sync = sync + 1'b1;
   endfunction

   function mss_pkg::rsp_type advance_mode(mss_pkg::req_type r);
      mss_pkg::rsp_type           o;
      logic [7:0]                 checked, flt, hb, sick;
      int                         n, lb;
      bit                         go;
      logic [mss_pkg::TICK_W-1:0] limit;
      mss_pkg::status_type        st;
      logic                       ok;
      st = mss_pkg::ST_MOVED;
      ok = 1'b1;
      n = (int'(axes) > mss_pkg::MAX_AXES) ? mss_pkg::MAX_AXES : int'(axes);
      checked = 8'((1 << n) - 1);
      flt = r.fault_bits & checked;
      hb = r.hb_lost_bits & checked;
      sick = flt | hb;
      lb = first_set(sick);
      o.bad_axis = (lb < 0) ? '0 : mss_pkg::AXIS_IDX_W'(lb);
      limit = (recover_ticks == 0) ? mss_pkg::TICK_W'(1) : recover_ticks;
      case (r.cmd)
         mss_pkg::CMD_SET_CONFIGURED: begin
            st = (mode == mss_pkg::MODE_CONFIGURED) ? mss_pkg::ST_ALREADY : mss_pkg::ST_MOVED;
            mode = mss_pkg::MODE_CONFIGURED;
         end
         mss_pkg::CMD_INIT: begin
            if (admitted(mode_bit(mss_pkg::MODE_CONFIGURED), mss_pkg::MODE_ARMED, st, ok)) begin
               ok = 1'b0;
               if (!r.start_ok) st = mss_pkg::ST_START_FAIL;
               else if (!r.running) begin
                  mode = mss_pkg::MODE_STANDBY;
                  st = mss_pkg::ST_NOT_RUNNING;
               end else if (flt != 0 || latch) begin
                  latch = 1'b1;
                  halted = 1'b1;
                  mode = mss_pkg::MODE_FAULTED;
                  if (flt != 0) begin
                     st = mss_pkg::ST_AXIS_FAULT;
                     o.bad_axis = mss_pkg::AXIS_IDX_W'(first_set(flt));
                  end else st = mss_pkg::ST_FAULT_LATCHED;
               end else if (hb != 0) begin
                  latch = 1'b0;
                  halted = 1'b0;
                  mode = mss_pkg::MODE_STANDBY;
                  st = mss_pkg::ST_HEARTBEAT;
                  o.bad_axis = mss_pkg::AXIS_IDX_W'(first_set(hb));
               end else begin
                  clear_faults_and_sync();
                  mode = mss_pkg::MODE_ARMED;
                  st = mss_pkg::ST_MOVED;
                  ok = 1'b1;
               end
            end
         end
         mss_pkg::CMD_ENABLE, mss_pkg::CMD_RELEASE: begin
            if (r.cmd == mss_pkg::CMD_ENABLE)
               go = admitted(mode_bit(mss_pkg::MODE_STANDBY), mss_pkg::MODE_ARMED, st, ok);
            else go = admitted(mode_bit(mss_pkg::MODE_ARMED), mss_pkg::MODE_RUNNING, st, ok);
            if (go) begin
               ok = 1'b0;
               if (!r.running) st = mss_pkg::ST_NOT_RUNNING;
               else if (latch) st = mss_pkg::ST_FAULT_LATCHED;
               else if (lb >= 0) st = flt[lb] ? mss_pkg::ST_AXIS_FAULT : mss_pkg::ST_HEARTBEAT;
               else begin
                  mode = (r.cmd == mss_pkg::CMD_ENABLE) ? mss_pkg::MODE_ARMED
                                                        : mss_pkg::MODE_RUNNING;
                  st = mss_pkg::ST_MOVED;
                  ok = 1'b1;
               end
            end
         end
         mss_pkg::CMD_DISABLE: begin
            if (admitted(mode_bit(mss_pkg::MODE_STANDBY) | mode_bit(mss_pkg::MODE_ARMED) |
                         mode_bit(mss_pkg::MODE_RUNNING), mss_pkg::MODE_STANDBY, st, ok)) begin
               if (!r.running) begin
                  st = mss_pkg::ST_NOT_RUNNING;
                  ok = 1'b0;
               end else mode = mss_pkg::MODE_STANDBY;
            end
         end
         mss_pkg::CMD_HALT: begin
            if (admitted(mode_bit(mss_pkg::MODE_RUNNING), mss_pkg::MODE_ARMED, st, ok))
               mode = mss_pkg::MODE_ARMED;
         end
         mss_pkg::CMD_RECOVER: begin
            if (admitted(mode_bit(mss_pkg::MODE_FAULTED), mss_pkg::MODE_STANDBY, st, ok)) begin
               ok = 1'b0;
               if (!r.running) st = mss_pkg::ST_NOT_RUNNING;
               else if (!r.reset_ok) begin
                  mode = mss_pkg::MODE_FAULTED;
                  st = mss_pkg::ST_RESET_FAIL;
               end else if (sick == 0) begin
                  clear_faults_and_sync();
                  mode = mss_pkg::MODE_STANDBY;
                  st = mss_pkg::ST_MOVED;
                  ok = 1'b1;
               end else begin
                  elapsed = '0;
                  mode = mss_pkg::MODE_RECOVERING;
                  st = mss_pkg::ST_RECOVER_PENDING;
               end
            end
         end
         mss_pkg::CMD_SHUTDOWN: begin
            elapsed = '0;
            mode = mss_pkg::MODE_CONFIGURED;
            if (r.running && !r.stop_ok) begin
               st = mss_pkg::ST_GRACEFUL_FAIL;
               ok = 1'b0;
            end else clear_faults_and_sync();
         end
         mss_pkg::CMD_TICK: begin
            if (mode == mss_pkg::MODE_RECOVERING) begin
               if (sick == 0) begin
                  clear_faults_and_sync();
                  mode = mss_pkg::MODE_STANDBY;
                  st = mss_pkg::ST_MOVED;
               end else begin
                  elapsed = elapsed + 1'b1;
                  ok = 1'b0;
                  if (elapsed >= limit) begin
                     mode = mss_pkg::MODE_FAULTED;
                     st = mss_pkg::ST_RECOVER_TIMEOUT;
                  end else st = mss_pkg::ST_RECOVER_PENDING;
               end
            end else if ((mode == mss_pkg::MODE_ARMED || mode == mss_pkg::MODE_RUNNING) &&
                         sick != 0) begin
               mode = mss_pkg::MODE_FAULTED;
               latch = 1'b1;
               halted = 1'b1;
               st = mss_pkg::ST_AUTO_FAULTED;
               ok = 1'b0;
            end else st = mss_pkg::ST_NO_CHANGE;
         end
         default: begin
            st = mss_pkg::ST_ILLEGAL;
            ok = 1'b0;
         end
      endcase
      o.success = ok;
      o.status = st;
      o.mode_now = mode;
      if (mode == mss_pkg::MODE_RUNNING) o.intent = mss_pkg::INTENT_RUN;
      else if (mode == mss_pkg::MODE_ARMED || mode == mss_pkg::MODE_FAULTED ||
               mode == mss_pkg::MODE_RECOVERING)
         o.intent = mss_pkg::INTENT_HALT;
      else o.intent = mss_pkg::INTENT_DISABLE;
      o.fault_latched = latch;
      o.halted_by_fault = halted;
      o.sync_sequence = sync;
      return o;
   endfunction

   function void note_request(mss_pkg::req_type r);
      mss_pkg::rsp_type want;
      want = advance_mode(r);
      status_seen[want.status]++;
      requests++;
      outcomes_due.push_back(want);
   endfunction

   function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   function void check_response(mss_pkg::rsp_type got);
      mss_pkg::rsp_type want;
      responses++;
      if (outcomes_due.size() == 0) begin
         $error("response with no request outstanding: status %0d mode %0d",
                got.status, got.mode_now);
         failures++;
         return;
      end
      want = outcomes_due.pop_front();
      compare_field("success", want.success, got.success);
      compare_field("status", want.status, got.status);
      compare_field("mode_now", want.mode_now, got.mode_now);
      compare_field("axis_intent", want.intent, got.intent);
      compare_field("global_fault_out", want.fault_latched, got.fault_latched);
      compare_field("halted_by_fault_out", want.halted_by_fault, got.halted_by_fault);
      compare_field("bad_axis", want.bad_axis, got.bad_axis);
      compare_field("sync_sequence", want.sync_sequence, got.sync_sequence);
   endfunction
endclass

module testbench;
   localparam logic [mss_pkg::CMD_W-1:0] CMD_UNKNOWN_FIRST = 4'd9;
   localparam logic [mss_pkg::CMD_W-1:0] CMD_UNKNOWN_LAST  = 4'd15;
   localparam int                        PHASES            = 6;
   localparam int                        PHASE_ITEMS       = 165;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [mss_pkg::CMD_W-1:0]      req_cmd = '0;
   logic [mss_pkg::AXIS_W-1:0]     req_axis_fault_bits = '0;
   logic [mss_pkg::AXIS_W-1:0]     req_axis_heartbeat_lost_bits = '0;
   logic                           req_master_start_ok = 1'b0;
   logic                           req_master_running = 1'b0;
   logic                           req_fault_reset_ok = 1'b0;
   logic                           req_graceful_stop_ok = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_success;
   logic [3:0]                     rsp_status;
   logic [2:0]                     rsp_mode_now;
   logic [1:0]                     rsp_axis_intent;
   logic                           rsp_global_fault_out;
   logic                           rsp_halted_by_fault_out;
   logic [mss_pkg::AXIS_IDX_W-1:0] rsp_bad_axis;
   logic [mss_pkg::SYNC_W-1:0]     rsp_sync_sequence;
   logic                           csr_we = 1'b0;
   logic [mss_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [mss_pkg::CSR_DATA_W-1:0] csr_data = '0;

   bit                             traffic_gaps = 1'b1;
   int                             phase_items;
   int                             register_settings = 1;
   supervisor_scoreboard           board;

   motion_system_mode_supervisor_top i_dut (
      .clock                        (clock),
      .reset                        (reset),
      .req_valid                    (req_valid),
      .req_ready                    (req_ready),
      .req_cmd                      (req_cmd),
      .req_axis_fault_bits          (req_axis_fault_bits),
      .req_axis_heartbeat_lost_bits (req_axis_heartbeat_lost_bits),
      .req_master_start_ok          (req_master_start_ok),
      .req_master_running           (req_master_running),
      .req_fault_reset_ok           (req_fault_reset_ok),
      .req_graceful_stop_ok         (req_graceful_stop_ok),
      .rsp_valid                    (rsp_valid),
      .rsp_ready                    (rsp_ready),
      .rsp_success                  (rsp_success),
      .rsp_status                   (rsp_status),
      .rsp_mode_now                 (rsp_mode_now),
      .rsp_axis_intent              (rsp_axis_intent),
      .rsp_global_fault_out         (rsp_global_fault_out),
      .rsp_halted_by_fault_out      (rsp_halted_by_fault_out),
      .rsp_bad_axis                 (rsp_bad_axis),
      .rsp_sync_sequence            (rsp_sync_sequence),
      .csr_we                       (csr_we),
      .csr_index                    (csr_index),
      .csr_data                     (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("testbench failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= !(traffic_gaps && $urandom_range(99) < 37);
   end

   always @(posedge clock) begin
      mss_pkg::req_type seen;
      mss_pkg::rsp_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.success = rsp_success;
            got.status = mss_pkg::status_type'(rsp_status);
            got.mode_now = mss_pkg::mode_type'(rsp_mode_now);
            got.intent = mss_pkg::intent_type'(rsp_axis_intent);
            got.fault_latched = rsp_global_fault_out;
            got.halted_by_fault = rsp_halted_by_fault_out;
            got.bad_axis = rsp_bad_axis;
            got.sync_sequence = rsp_sync_sequence;
            board.check_response(got);
         end
         if (req_valid && req_ready) begin
            seen.cmd = req_cmd;
            seen.fault_bits = req_axis_fault_bits;
            seen.hb_lost_bits = req_axis_heartbeat_lost_bits;
            seen.start_ok = req_master_start_ok;
            seen.running = req_master_running;
            seen.reset_ok = req_fault_reset_ok;
            seen.stop_ok = req_graceful_stop_ok;
            board.note_request(seen);
         end
      end
   end

   function automatic mss_pkg::req_type compose_request(logic [mss_pkg::CMD_W-1:0] cmd,
                                                        logic [mss_pkg::AXIS_W-1:0] flt,
                                                        logic [mss_pkg::AXIS_W-1:0] hb,
                                                        logic start_ok, logic running,
                                                        logic reset_ok, logic stop_ok);
      mss_pkg::req_type r;
      r.cmd = cmd;
      r.fault_bits = flt;
      r.hb_lost_bits = hb;
      r.start_ok = start_ok;
      r.running = running;
      r.reset_ok = reset_ok;
      r.stop_ok = stop_ok;
      return r;
   endfunction

   function automatic logic [mss_pkg::AXIS_W-1:0] axis_flags(int sick_pct);
      if ($urandom_range(99) >= sick_pct) return '0;
      if ($urandom_range(1)) return mss_pkg::AXIS_W'(1) << $urandom_range(mss_pkg::AXIS_W - 1);
      return mss_pkg::AXIS_W'($urandom);
   endfunction

   function automatic mss_pkg::req_type random_request(logic [mss_pkg::CMD_W-1:0] cmd,
                                                       int sick_pct);
      return compose_request(cmd, axis_flags(sick_pct), axis_flags(sick_pct),
                             $urandom_range(9) != 0, $urandom_range(9) != 0,
                             $urandom_range(4) != 0, $urandom_range(4) != 0);
   endfunction

   task automatic issue(mss_pkg::req_type r);
      while (traffic_gaps && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= r.cmd;
      req_axis_fault_bits <= r.fault_bits;
      req_axis_heartbeat_lost_bits <= r.hb_lost_bits;
      req_master_start_ok <= r.start_ok;
      req_master_running <= r.running;
      req_fault_reset_ok <= r.reset_ok;
      req_graceful_stop_ok <= r.stop_ok;
      do @(posedge clock); while (!req_ready);
      phase_items++;
   endtask

   task automatic settle();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (board.pending() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_registers(logic [mss_pkg::CNT_W-1:0] count,
                                  logic [mss_pkg::TICK_W-1:0] ticks);
      logic [mss_pkg::CSR_DATA_W-1:0] count_word;
      count_word = {(mss_pkg::CSR_DATA_W - mss_pkg::CNT_W)'($urandom), count};
      csr_we <= 1'b1;
      csr_index <= mss_pkg::CSR_AXES;
      csr_data <= count_word;
      @(posedge clock);
      csr_index <= mss_pkg::CSR_RECOVER_TIMEOUT;
      csr_data <= ticks;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_registers(count_word, ticks);
      register_settings++;
   endtask

   task automatic run_lifecycle();
      if ($urandom_range(1)) issue(random_request(mss_pkg::CMD_SET_CONFIGURED, 10));
      issue(random_request(mss_pkg::CMD_INIT, 10));
      issue(random_request(mss_pkg::CMD_ENABLE, 10));
      issue(random_request(mss_pkg::CMD_RELEASE, 10));
      repeat ($urandom_range(1, 6)) issue(random_request(mss_pkg::CMD_TICK, 15));
      case ($urandom_range(2))
         0: issue(random_request(mss_pkg::CMD_HALT, 10));
         1: issue(random_request(mss_pkg::CMD_DISABLE, 10));
         default: issue(random_request(mss_pkg::CMD_RELEASE, 10));
      endcase
      issue(random_request(mss_pkg::CMD_RECOVER, 50));
      repeat ($urandom_range(0, 5)) issue(random_request(mss_pkg::CMD_TICK, 40));
      if ($urandom_range(2) == 0) issue(random_request(mss_pkg::CMD_SHUTDOWN, 10));
   endtask

   task automatic run_noise();
      logic [mss_pkg::CMD_W-1:0] cmd;
      if ($urandom_range(19) == 0)
         cmd = mss_pkg::CMD_W'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));
      else cmd = mss_pkg::CMD_W'($urandom_range(mss_pkg::CMD_SET_CONFIGURED, mss_pkg::CMD_TICK));
      issue(random_request(cmd, 30));
   endtask

   initial begin
      logic [mss_pkg::CNT_W-1:0]  counts[PHASES];
      logic [mss_pkg::TICK_W-1:0] timeouts[PHASES];
      int                         total;
      counts = '{mss_pkg::AXES_RESET, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8};
      timeouts = '{mss_pkg::TIMEOUT_RESET, 16'd1, 16'd0, 16'hFFFF, 16'd2, 16'd5};
      board = new();
      phase_items = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(compose_request(CMD_UNKNOWN_LAST, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_INIT, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_SET_CONFIGURED, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_SET_CONFIGURED, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_INIT, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_INIT, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_ENABLE, 8'h01, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_ENABLE, 8'h00, 8'h80, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_ENABLE, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_RELEASE, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_RELEASE, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_HALT, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_DISABLE, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_ENABLE, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_RELEASE, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_TICK, 8'h80, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_RECOVER, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1));
      issue(compose_request(mss_pkg::CMD_RECOVER, 8'h00, 8'h02, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_TICK, 8'h00, 8'h02, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_TICK, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_SHUTDOWN, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0));
      issue(compose_request(mss_pkg::CMD_INIT, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_SET_CONFIGURED, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_INIT, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_SET_CONFIGURED, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_INIT, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      issue(compose_request(mss_pkg::CMD_SHUTDOWN, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
      total = phase_items;

      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            settle();
            write_registers(counts[p], timeouts[p]);
         end
         traffic_gaps = (p != 2);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(9) < 7) run_lifecycle();
            else run_noise();
         end
         total += phase_items;
      end

      settle();
      if (board.pending() != 0) begin
         $error("%0d expected responses never arrived", board.pending());
         board.failures++;
      end
      $display("covered %0d requests, %0d responses checked, %0d register settings",
               board.requests, board.responses, register_settings);
      $display("recover pending %0d, recover timeouts %0d, auto faults %0d, illegal %0d",
               board.status_seen[mss_pkg::ST_RECOVER_PENDING],
               board.status_seen[mss_pkg::ST_RECOVER_TIMEOUT],
               board.status_seen[mss_pkg::ST_AUTO_FAULTED],
               board.status_seen[mss_pkg::ST_ILLEGAL]);
      if (board.failures == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end
endmodule

### motion_system_mode_supervisor_top.f
rtl/mss_pkg.sv
rtl/mss_req_stage.sv
rtl/mss_step.sv
rtl/motion_system_mode_supervisor_top.sv
sim/testbench.sv
